// File: hdl/reaction_term_evaluator_macros.svh
// assertion macros for the reaction term evaluator
`ifndef REACTION_TERM_EVALUATOR_MACROS_SVH
`define REACTION_TERM_EVALUATOR_MACROS_SVH
`ifndef SYNTHESIS
`define RTE_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rte implication check failed");
`define RTE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rte next-cycle check failed");
`else
`define RTE_ASSERT_IMPL(name, clk, rst, ante, cons)
`define RTE_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// File: hdl/rte_pkg.sv
// types, constants and fixed-point helpers for the reaction term evaluator
`timescale 1ns / 1ps
`default_nettype none
package rte_pkg;

   localparam int FRAC_BITS = 24;
   localparam int DATA_W    = 32;
   localparam int OP_W      = DATA_W + 1;
   localparam int WIDE_W    = DATA_W + 4;
   localparam int PROD_W    = 2 * OP_W;
   localparam int NUMER_W   = FRAC_BITS + DATA_W + 1;
   localparam int QUO_BITS  = DATA_W;
   localparam int MODEL_W   = 3;

   localparam logic [MODEL_W-1:0] MODEL_LINEAR = 3'd0;
   localparam logic [MODEL_W-1:0] MODEL_BRUSS  = 3'd1;
   localparam logic [MODEL_W-1:0] MODEL_FHN    = 3'd2;
   localparam logic [MODEL_W-1:0] MODEL_ROGERS = 3'd3;
   localparam logic [MODEL_W-1:0] MODEL_ALIEV  = 3'd4;
   localparam logic [MODEL_W-1:0] MODEL_RESET  = MODEL_FHN;

   typedef logic signed [DATA_W-1:0]  data_type;
   typedef logic signed [OP_W-1:0]    op_type;
   typedef logic signed [WIDE_W-1:0]  wide_type;
   typedef logic [NUMER_W-1:0]        numer_type;

   localparam data_type QMAX = 32'sh7FFFFFFF;
   localparam data_type QMIN = 32'sh80000000;

   localparam op_type Q_ONE   = op_type'(longint'(1) <<< FRAC_BITS);
   localparam op_type C_0P175 = op_type'(((longint'(175) <<< (FRAC_BITS + 1)) + 1000) / 2000);
   localparam op_type C_0P12  = op_type'(((longint'(12) <<< (FRAC_BITS + 1)) + 100) / 200);
   localparam op_type C_0P03  = op_type'(((longint'(3) <<< (FRAC_BITS + 1)) + 100) / 200);
   localparam op_type C_0P55  = op_type'(((longint'(55) <<< (FRAC_BITS + 1)) + 100) / 200);
   localparam op_type C_0P011 = op_type'(((longint'(11) <<< (FRAC_BITS + 1)) + 1000) / 2000);
   localparam op_type C_0P26  = op_type'(((longint'(26) <<< (FRAC_BITS + 1)) + 100) / 200);
   localparam op_type C_0P13  = op_type'(((longint'(13) <<< (FRAC_BITS + 1)) + 100) / 200);
   localparam op_type C_0P1   = op_type'(((longint'(1) <<< (FRAC_BITS + 1)) + 10) / 20);
   localparam op_type C_0P013 = op_type'(((longint'(13) <<< (FRAC_BITS + 1)) + 1000) / 2000);
   localparam op_type C_0P15  = op_type'(((longint'(15) <<< (FRAC_BITS + 1)) + 100) / 200);
   localparam op_type C_0P2   = op_type'(((longint'(2) <<< (FRAC_BITS + 1)) + 10) / 20);
   localparam op_type C_0P3   = op_type'(((longint'(3) <<< (FRAC_BITS + 1)) + 10) / 20);
   localparam op_type C_0P002 = op_type'(((longint'(2) <<< (FRAC_BITS + 1)) + 1000) / 2000);
   localparam op_type C_1P15  = C_0P15 + Q_ONE;

   typedef struct packed {
      logic signed [DATA_W-1:0] u_value;
      logic signed [DATA_W-1:0] v_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] du_rate;
      logic signed [DATA_W-1:0] dv_rate;
      logic                     saturated;
      logic                     divide_error;
   } rsp_type;

   typedef struct packed {
      data_type val;
      logic     clip;
   } qres_type;

   typedef struct packed {
      logic [MODEL_W-1:0] mode;
      data_type           du;
      data_type           dv;
      data_type           h;
      data_type           numer;
      op_type             den;
      logic               clip;
   } side_type;

   typedef struct packed {
      logic [DATA_W-1:0] rem;
      logic [DATA_W-1:0] numer_lo;
      logic [DATA_W-1:0] quo;
      logic [DATA_W-1:0] dvsr;
      logic              ovf;
      logic              neg;
      logic              zero;
      logic              num_neg;
   } div_type;

   typedef struct packed {
      side_type side;
      div_type  div;
   } pipe_type;

   function automatic qres_type qmul(input op_type a, input op_type b);
      logic [OP_W-1:0]   ma;
      logic [OP_W-1:0]   mb;
      logic [PROD_W-1:0] p;
      logic [PROD_W-1:0] m;
      qres_type          r;
      ma = a[OP_W-1] ? OP_W'(-a) : OP_W'(a);
      mb = b[OP_W-1] ? OP_W'(-b) : OP_W'(b);
      p  = PROD_W'(ma) * PROD_W'(mb);
      m  = (p + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      r.clip = 1'b0;
      if (a[OP_W-1] ^ b[OP_W-1]) begin
         if (m > (PROD_W'(1) << (DATA_W - 1))) begin
            r.val  = QMIN;
            r.clip = 1'b1;
         end else begin
            r.val = data_type'(PROD_W'(0) - m);
         end
      end else begin
         if (m > PROD_W'(QMAX)) begin
            r.val  = QMAX;
            r.clip = 1'b1;
         end else begin
            r.val = data_type'(m);
         end
      end
      return r;
   endfunction

   function automatic qres_type sat(input wide_type x);
      qres_type r;
      r.clip = 1'b0;
      r.val  = data_type'(x);
      if (x > wide_type'(QMAX)) begin
         r.val  = QMAX;
         r.clip = 1'b1;
      end else if (x < wide_type'(QMIN)) begin
         r.val  = QMIN;
         r.clip = 1'b1;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: hdl/rte_front.sv
// four-stage product pipeline forming the reaction terms up to the divider
`timescale 1ns / 1ps
`default_nettype none
module rte_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire logic                         in_valid,
   input  wire rte_pkg::req_type             in_data,
   input  wire logic [rte_pkg::MODEL_W-1:0]  mode,
   output logic                              out_valid,
   output rte_pkg::side_type                 out_side
);

   typedef struct packed {
      logic [rte_pkg::MODEL_W-1:0] mode;
      rte_pkg::data_type           u;
      rte_pkg::data_type           v;
      rte_pkg::data_type           a;
      rte_pkg::data_type           b;
      rte_pkg::data_type           c;
      rte_pkg::data_type           d;
      rte_pkg::data_type           du;
      rte_pkg::data_type           dv;
      logic                        clip;
   } s1_type;

   typedef struct packed {
      logic [rte_pkg::MODEL_W-1:0] mode;
      rte_pkg::data_type           u;
      rte_pkg::data_type           e;
      rte_pkg::data_type           f;
      rte_pkg::data_type           h;
      rte_pkg::data_type           b;
      rte_pkg::data_type           c;
      rte_pkg::data_type           du;
      rte_pkg::data_type           dv;
      logic                        clip;
   } s2_type;

   typedef struct packed {
      logic [rte_pkg::MODEL_W-1:0] mode;
      rte_pkg::data_type           u;
      rte_pkg::data_type           g;
      rte_pkg::data_type           f;
      rte_pkg::data_type           h;
      rte_pkg::data_type           b;
      rte_pkg::data_type           c;
      rte_pkg::data_type           du;
      rte_pkg::data_type           dv;
      logic                        clip;
   } s3_type;

   s1_type s1_in, s1_ff;
   s2_type s2_in, s2_ff;
   s3_type s3_in, s3_ff;
   rte_pkg::side_type s4_in, s4_ff;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;

   rte_pkg::op_type   a1, a2, b1, b2, c1, c2, d1, d2;
   rte_pkg::qres_type qa, qb, qc, qd, lin_du, lin_dv;
   rte_pkg::op_type   e1, e2, f1, f2;
   rte_pkg::qres_type qe, qf, qh;
   rte_pkg::op_type   g1, g2;
   rte_pkg::qres_type qg, x3, y3;
   rte_pkg::qres_type x4;

   // stage 1: first products and the linear model
   always_comb begin
      rte_pkg::op_type u33;
      rte_pkg::op_type v33;
      u33 = rte_pkg::op_type'(in_data.u_value);
      v33 = rte_pkg::op_type'(in_data.v_value);
      a1 = '0; a2 = '0; b1 = '0; b2 = '0;
      c1 = '0; c2 = '0; d1 = '0; d2 = '0;
      lin_du = '0;
      lin_dv = '0;
      case (mode)
         rte_pkg::MODEL_LINEAR: begin
            lin_du = rte_pkg::sat((rte_pkg::wide_type'(in_data.u_value) <<< 2)
                                + (rte_pkg::wide_type'(in_data.v_value) <<< 2));
            lin_dv = rte_pkg::sat(rte_pkg::wide_type'(0)
                                - rte_pkg::wide_type'(in_data.u_value) * rte_pkg::wide_type'(5)
                                - (rte_pkg::wide_type'(in_data.v_value) <<< 2));
         end
         rte_pkg::MODEL_BRUSS: begin
            a1 = u33; a2 = u33;
         end
         rte_pkg::MODEL_FHN: begin
            a1 = rte_pkg::C_0P175; a2 = u33;
            b1 = rte_pkg::C_0P03;  b2 = v33;
            c1 = rte_pkg::C_0P55;  c2 = v33;
         end
         rte_pkg::MODEL_ROGERS: begin
            a1 = rte_pkg::C_0P26;  a2 = u33;
            b1 = u33;              b2 = v33;
            c1 = rte_pkg::C_0P013; c2 = u33 - v33;
         end
         rte_pkg::MODEL_ALIEV: begin
            a1 = u33; a2 = u33 - rte_pkg::C_0P15;
            b1 = u33; b2 = v33;
            c1 = rte_pkg::C_0P2; c2 = v33;
            d1 = u33; d2 = u33 - rte_pkg::C_1P15;
         end
         default: begin
         end
      endcase
   end

   assign qa = rte_pkg::qmul(a1, a2);
   assign qb = rte_pkg::qmul(b1, b2);
   assign qc = rte_pkg::qmul(c1, c2);
   assign qd = rte_pkg::qmul(d1, d2);

   always_comb begin
      s1_in.mode = mode;
      s1_in.u    = in_data.u_value;
      s1_in.v    = in_data.v_value;
      s1_in.a    = qa.val;
      s1_in.b    = qb.val;
      s1_in.c    = qc.val;
      s1_in.d    = qd.val;
      s1_in.du   = lin_du.val;
      s1_in.dv   = lin_dv.val;
      s1_in.clip = qa.clip | qb.clip | qc.clip | qd.clip | lin_du.clip | lin_dv.clip;
   end

   // stage 2: second products and the Aliev-Panfilov h sum
   always_comb begin
      rte_pkg::op_type u33;
      u33 = rte_pkg::op_type'(s1_ff.u);
      e1 = '0; e2 = '0; f1 = '0; f2 = '0;
      qh = '0;
      case (s1_ff.mode)
         rte_pkg::MODEL_BRUSS: begin
            e1 = rte_pkg::op_type'(s1_ff.a); e2 = rte_pkg::op_type'(s1_ff.v);
         end
         rte_pkg::MODEL_FHN: begin
            e1 = rte_pkg::op_type'(s1_ff.a); e2 = u33 - rte_pkg::C_0P12;
            f1 = rte_pkg::C_0P011;           f2 = u33 - rte_pkg::op_type'(s1_ff.c);
         end
         rte_pkg::MODEL_ROGERS: begin
            e1 = rte_pkg::op_type'(s1_ff.a); e2 = u33 - rte_pkg::C_0P13;
            f1 = rte_pkg::op_type'(s1_ff.b); f2 = rte_pkg::C_0P1;
         end
         rte_pkg::MODEL_ALIEV: begin
            e1 = rte_pkg::op_type'(s1_ff.a); e2 = rte_pkg::Q_ONE - u33;
            qh = rte_pkg::sat(rte_pkg::wide_type'(s1_ff.v)
                            + (rte_pkg::wide_type'(s1_ff.d) <<< 3));
         end
         default: begin
         end
      endcase
   end

   assign qe = rte_pkg::qmul(e1, e2);
   assign qf = rte_pkg::qmul(f1, f2);

   always_comb begin
      s2_in.mode = s1_ff.mode;
      s2_in.u    = s1_ff.u;
      s2_in.e    = qe.val;
      s2_in.f    = qf.val;
      s2_in.h    = qh.val;
      s2_in.b    = s1_ff.b;
      s2_in.c    = s1_ff.c;
      s2_in.du   = s1_ff.du;
      s2_in.dv   = s1_ff.dv;
      s2_in.clip = s1_ff.clip | qe.clip | qf.clip | qh.clip;
   end

   // stage 3: cubic term, Brusselator sums and the Aliev-Panfilov du sum
   always_comb begin
      g1 = '0; g2 = '0;
      x3 = '0; y3 = '0;
      case (s2_ff.mode)
         rte_pkg::MODEL_BRUSS: begin
            x3 = rte_pkg::sat((rte_pkg::wide_type'(rte_pkg::Q_ONE) <<< 1)
                            - rte_pkg::wide_type'(s2_ff.u) * rte_pkg::wide_type'(6)
                            + rte_pkg::wide_type'(s2_ff.e));
            y3 = rte_pkg::sat(rte_pkg::wide_type'(s2_ff.u) * rte_pkg::wide_type'(5)
                            - rte_pkg::wide_type'(s2_ff.e));
         end
         rte_pkg::MODEL_FHN, rte_pkg::MODEL_ROGERS: begin
            g1 = rte_pkg::op_type'(s2_ff.e);
            g2 = rte_pkg::Q_ONE - rte_pkg::op_type'(s2_ff.u);
         end
         rte_pkg::MODEL_ALIEV: begin
            x3 = rte_pkg::sat((rte_pkg::wide_type'(s2_ff.e) <<< 3)
                            - rte_pkg::wide_type'(s2_ff.b));
         end
         default: begin
         end
      endcase
   end

   assign qg = rte_pkg::qmul(g1, g2);

   always_comb begin
      s3_in.mode = s2_ff.mode;
      s3_in.u    = s2_ff.u;
      s3_in.g    = qg.val;
      s3_in.f    = s2_ff.f;
      s3_in.h    = s2_ff.h;
      s3_in.b    = s2_ff.b;
      s3_in.c    = s2_ff.c;
      s3_in.du   = s2_ff.du;
      s3_in.dv   = s2_ff.dv;
      s3_in.clip = s2_ff.clip | qg.clip | x3.clip | y3.clip;
      if (s2_ff.mode == rte_pkg::MODEL_BRUSS) begin
         s3_in.du = x3.val;
         s3_in.dv = y3.val;
      end else if (s2_ff.mode == rte_pkg::MODEL_ALIEV) begin
         s3_in.du = x3.val;
      end
   end

   // stage 4: FitzHugh-Nagumo and Rogers sums and divider operands
   always_comb begin
      x4 = '0;
      s4_in.mode  = s3_ff.mode;
      s4_in.du    = s3_ff.du;
      s4_in.dv    = s3_ff.dv;
      s4_in.h     = s3_ff.h;
      s4_in.numer = s3_ff.c;
      s4_in.den   = rte_pkg::op_type'(s3_ff.u) + rte_pkg::C_0P3;
      case (s3_ff.mode)
         rte_pkg::MODEL_FHN: begin
            x4 = rte_pkg::sat(rte_pkg::wide_type'(s3_ff.g) - rte_pkg::wide_type'(s3_ff.b));
            s4_in.du = x4.val;
            s4_in.dv = s3_ff.f;
         end
         rte_pkg::MODEL_ROGERS: begin
            x4 = rte_pkg::sat(rte_pkg::wide_type'(s3_ff.g) - rte_pkg::wide_type'(s3_ff.f));
            s4_in.du = x4.val;
            s4_in.dv = s3_ff.c;
         end
         default: begin
         end
      endcase
      s4_in.clip = s3_ff.clip | x4.clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_side  = s4_ff;

endmodule
`default_nettype wire

// File: hdl/rte_div_step.sv
// one restoring division step: one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module rte_div_step (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              in_valid,
   input  wire rte_pkg::pipe_type in_pipe,
   output logic                   out_valid,
   output rte_pkg::pipe_type      out_pipe
);

   rte_pkg::pipe_type pipe_in, pipe_ff;
   logic              valid_ff;
   logic [rte_pkg::DATA_W:0] trial;
   logic [rte_pkg::DATA_W:0] diff;
   logic                     take;

   always_comb begin
      trial = {in_pipe.div.rem, in_pipe.div.numer_lo[rte_pkg::DATA_W-1]};
      diff  = trial - {1'b0, in_pipe.div.dvsr};
      take  = trial >= {1'b0, in_pipe.div.dvsr};
      pipe_in = in_pipe;
      pipe_in.div.rem      = take ? diff[rte_pkg::DATA_W-1:0] : trial[rte_pkg::DATA_W-1:0];
      pipe_in.div.numer_lo = {in_pipe.div.numer_lo[rte_pkg::DATA_W-2:0], 1'b0};
      pipe_in.div.quo      = {in_pipe.div.quo[rte_pkg::DATA_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pipe_ff <= pipe_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pipe  = pipe_ff;

endmodule
`default_nettype wire

// File: hdl/rte_divider.sv
// pipelined fixed-point divider with overflow and zero-divisor detection
`timescale 1ns / 1ps
`default_nettype none
module rte_divider (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              in_valid,
   input  wire rte_pkg::side_type in_side,
   output logic                   out_valid,
   output rte_pkg::pipe_type      out_pipe
);

   rte_pkg::pipe_type   entry_in, entry_ff;
   logic                entry_valid_ff;
   logic [rte_pkg::OP_W-1:0]   den_mag;
   logic [rte_pkg::DATA_W-1:0] num_mag;
   rte_pkg::numer_type         nfull;
   rte_pkg::numer_type         nhigh;

   rte_pkg::pipe_type stage_pipe  [0:rte_pkg::QUO_BITS];
   logic              stage_valid [0:rte_pkg::QUO_BITS];

   always_comb begin
      den_mag = in_side.den[rte_pkg::OP_W-1] ? rte_pkg::OP_W'(-in_side.den)
                                             : rte_pkg::OP_W'(in_side.den);
      num_mag = in_side.numer[rte_pkg::DATA_W-1] ? rte_pkg::DATA_W'(-in_side.numer)
                                                 : rte_pkg::DATA_W'(in_side.numer);
      nfull = (rte_pkg::numer_type'(num_mag) << rte_pkg::FRAC_BITS)
            + rte_pkg::numer_type'(den_mag[rte_pkg::DATA_W-1:1]);
      nhigh = nfull >> rte_pkg::DATA_W;
      entry_in.side         = in_side;
      entry_in.div.rem      = nhigh[rte_pkg::DATA_W-1:0];
      entry_in.div.numer_lo = nfull[rte_pkg::DATA_W-1:0];
      entry_in.div.quo      = '0;
      entry_in.div.dvsr     = den_mag[rte_pkg::DATA_W-1:0];
      entry_in.div.ovf      = nhigh >= rte_pkg::numer_type'(den_mag[rte_pkg::DATA_W-1:0]);
      entry_in.div.neg      = in_side.numer[rte_pkg::DATA_W-1] ^ in_side.den[rte_pkg::OP_W-1];
      entry_in.div.zero     = in_side.den == '0;
      entry_in.div.num_neg  = in_side.numer[rte_pkg::DATA_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (advance) begin
         entry_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_ff <= entry_in;
      end
   end

   assign stage_pipe[0]  = entry_ff;
   assign stage_valid[0] = entry_valid_ff;

   genvar gi;
   generate
      for (gi = 0; gi < rte_pkg::QUO_BITS; gi++) begin : g_step
         rte_div_step u_step (
            .clock     (clock),
            .reset     (reset),
            .advance   (advance),
            .in_valid  (stage_valid[gi]),
            .in_pipe   (stage_pipe[gi]),
            .out_valid (stage_valid[gi+1]),
            .out_pipe  (stage_pipe[gi+1])
         );
      end
   endgenerate

   assign out_valid = stage_valid[rte_pkg::QUO_BITS];
   assign out_pipe  = stage_pipe[rte_pkg::QUO_BITS];

endmodule
`default_nettype wire

// File: hdl/reaction_term_evaluator.sv
// Reaction term evaluator: one mesh point (u, v) in, reaction rates (du, dv) out, in signed
// Q8.24 for the model chosen by model_select. The block takes one transaction per cycle when
// the output is not stalled. A result passes through four product stages, one divider set-up
// stage, 32 restoring-division stages (one quotient bit each, used by Aliev-Panfilov) and two
// closing stages, the last of which is the output register. The whole pipeline holds while a
// result is stalled at the output, so req_stall follows rsp_stall in that case. Write
// model_select only while no transaction is in flight; csr_ready is always high.
`timescale 1ns / 1ps
`default_nettype none
`include "reaction_term_evaluator_macros.svh"
module reaction_term_evaluator (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire rte_pkg::req_type             req_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output rte_pkg::rsp_type                  rsp_data,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [rte_pkg::MODEL_W-1:0]  csr_data
);

   typedef struct packed {
      logic [rte_pkg::MODEL_W-1:0] mode;
      rte_pkg::data_type           du;
      rte_pkg::data_type           dv;
      rte_pkg::data_type           g;
      rte_pkg::data_type           h;
      logic                        clip;
      logic                        derr;
   } fin_type;

   logic [rte_pkg::MODEL_W-1:0] model_select_ff;
   logic                        advance;
   logic                        front_valid;
   rte_pkg::side_type           front_side;
   logic                        div_valid;
   rte_pkg::pipe_type           div_pipe;
   fin_type                     a_in, a_ff;
   logic                        a_valid_ff;
   rte_pkg::qres_type           quot;
   rte_pkg::qres_type           gsum;
   rte_pkg::qres_type           dprod;
   rte_pkg::rsp_type            rsp_data_in, rsp_data_ff;
   logic                        rsp_valid_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         model_select_ff <= rte_pkg::MODEL_RESET;
      end else if (csr_valid && csr_ready) begin
         model_select_ff <= csr_data;
      end
   end

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   rte_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .mode      (model_select_ff),
      .out_valid (front_valid),
      .out_side  (front_side)
   );

   rte_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (front_valid),
      .in_side   (front_side),
      .out_valid (div_valid),
      .out_pipe  (div_pipe)
   );

   // quotient clip and the 0.002 offset
   always_comb begin
      quot.clip = 1'b0;
      quot.val  = rte_pkg::data_type'(div_pipe.div.quo);
      if (div_pipe.div.zero) begin
         quot.val  = div_pipe.div.num_neg ? rte_pkg::QMIN : rte_pkg::QMAX;
         quot.clip = 1'b1;
      end else if (div_pipe.div.neg) begin
         if (div_pipe.div.ovf
             || div_pipe.div.quo > (rte_pkg::DATA_W'(1) << (rte_pkg::DATA_W - 1))) begin
            quot.val  = rte_pkg::QMIN;
            quot.clip = 1'b1;
         end else begin
            quot.val = rte_pkg::data_type'(rte_pkg::DATA_W'(0) - div_pipe.div.quo);
         end
      end else if (div_pipe.div.ovf
                   || div_pipe.div.quo > rte_pkg::DATA_W'(rte_pkg::QMAX)) begin
         quot.val  = rte_pkg::QMAX;
         quot.clip = 1'b1;
      end
      gsum = rte_pkg::sat(rte_pkg::wide_type'(rte_pkg::C_0P002)
                        + rte_pkg::wide_type'(quot.val));
      a_in.mode = div_pipe.side.mode;
      a_in.du   = div_pipe.side.du;
      a_in.dv   = div_pipe.side.dv;
      a_in.h    = div_pipe.side.h;
      a_in.g    = '0;
      a_in.clip = div_pipe.side.clip;
      a_in.derr = 1'b0;
      if (div_pipe.side.mode == rte_pkg::MODEL_ALIEV) begin
         a_in.g    = gsum.val;
         a_in.clip = div_pipe.side.clip | quot.clip | gsum.clip;
         a_in.derr = div_pipe.div.zero;
      end
   end

   // final product for the Aliev-Panfilov recovery rate
   always_comb begin
      dprod = rte_pkg::qmul(rte_pkg::op_type'(a_ff.g),
                            rte_pkg::op_type'(0) - rte_pkg::op_type'(a_ff.h));
      rsp_data_in.du_rate      = a_ff.du;
      rsp_data_in.dv_rate      = a_ff.dv;
      rsp_data_in.saturated    = a_ff.clip;
      rsp_data_in.divide_error = a_ff.derr;
      if (a_ff.mode == rte_pkg::MODEL_ALIEV) begin
         rsp_data_in.dv_rate   = dprod.val;
         rsp_data_in.saturated = a_ff.clip | dprod.clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff   <= div_valid;
         rsp_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff        <= a_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `RTE_ASSERT_IMPL(a_diverr_sat, clock, reset, rsp_valid_ff && rsp_data_ff.divide_error, rsp_data_ff.saturated)
   `RTE_ASSERT_IMPL(a_diverr_mode, clock, reset, a_valid_ff && (a_ff.mode != rte_pkg::MODEL_ALIEV), !a_ff.derr)
   `RTE_ASSERT_IMPL(a_unused_zero, clock, reset, a_valid_ff && (a_ff.mode > rte_pkg::MODEL_ALIEV), (a_ff.du == '0) && (a_ff.dv == '0) && !a_ff.clip)
   `RTE_ASSERT_NEXT(a_hold_pipe, clock, reset, rsp_valid_ff && rsp_stall, $stable(a_ff) && $stable(a_valid_ff))

endmodule
`default_nettype wire
